// ===== hw/rtl/msa_pkg.sv =====
// Package for the masked statistics accumulator: widths and shared types.
package msa_pkg;

    localparam int SampleBits   = 16;
    localparam int FractionBits = 16;
    localparam int MaxElements  = 1048576;
    localparam int PosBits      = 21;
    localparam int CountBits    = 21;
    localparam int TotalBits    = 36;
    localparam int SumBits      = 37;
    localparam int SquareBits   = 51;
    localparam int OutBits      = 32;

    // Wide working registers of the shared divide and square root unit
    localparam int WordBits     = 64;
    localparam int StepBits     = 7;
    localparam int RemBits      = OutBits + 2;
    localparam int AluBits      = OutBits + 3;

    // Iterations of each closing phase
    localparam int MeanSteps    = TotalBits + FractionBits;
    localparam int SquareSteps  = SquareBits + 2 * FractionBits;
    localparam int RootSteps    = OutBits;

    typedef logic signed [SampleBits-1:0] sample_t;
    typedef logic [PosBits-1:0]           pos_t;
    typedef logic [CountBits-1:0]         count_t;
    typedef logic [WordBits-1:0]          word_t;

endpackage

// ===== hw/rtl/masked_statistics_accumulator_core.sv =====
// Masked statistics accumulator: running count, sum, squares, extremes and final stats.
//
// Usage:
//   Input channel s_*: one sample per item with a valid_req mask bit and a
//   last bit that closes the set. Items that are not last are taken at one
//   item per cycle while s_ready is high and produce no result.
//   Output channel m_*: one item per set, carrying count, total, extremes with
//   their first positions, mean, rms and standard deviation (FractionBits
//   fraction bits). An empty set gives zeros, positions of all ones and
//   has_data low.
//   One shared subtractor does the closing work: a 52-step restoring divide
//   for the mean, an 83-step divide for the mean square and two 32-step square
//   roots, each phase after its own load state.
//   s_ready is low from the last item until its result enters the m_*
//   registers; the next set then streams in while that result waits.
//   Reset (aresetn low, synchronous) clears all accumulators and drops any
//   pending result. A stalled receiver holds the result in the m_* registers;
//   a following result waits in its output stage until they are free.
module masked_statistics_accumulator_core
    import msa_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_sample,
    input  logic                        s_valid_req,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [20:0]                 m_sample_count,
    output logic signed [35:0]          m_total,
    output logic signed [15:0]          m_min_value,
    output logic signed [20:0]          m_min_position,
    output logic signed [15:0]          m_max_value,
    output logic signed [20:0]          m_max_position,
    output logic signed [31:0]          m_mean_value,
    output logic [31:0]                 m_rms_value,
    output logic [31:0]                 m_std_deviation,
    output logic                        m_has_data
);

    typedef enum logic [3:0] {
        ST_ACC, ST_MEAN_LOAD, ST_MEAN_DIV, ST_MS_LOAD, ST_MS_DIV,
        ST_RMS_LOAD, ST_RMS_ROOT, ST_SD_LOAD, ST_SD_ROOT, ST_OUT
    } state_t;

    state_t state_reg;

    pos_t          position_reg;
    count_t        count_reg;
    logic signed [SumBits-1:0] sum_reg;
    logic [SquareBits-1:0]     square_reg;
    sample_t       min_reg, max_reg;
    pos_t          min_idx_reg, max_idx_reg;

    // shared iterative unit registers
    word_t         quo_reg;     // quotient / root result
    logic [RemBits-1:0] rem_reg;   // remainder of divide or root
    word_t         num_reg;     // dividend or radicand bits shifted out at the top
    logic [StepBits-1:0] step_reg;
    word_t         ms_reg;
    word_t         m2_reg;
    logic [OutBits-1:0] mmag_reg;
    logic [OutBits-1:0] rms_reg;
    logic          neg_reg;

    logic acc_take;
    logic out_load;
    assign s_ready  = (state_reg == ST_ACC);
    assign acc_take = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid || m_ready);

    // operands of the shared subtractor: divide step or root step
    logic               root_mode;
    logic [CountBits:0] div_shift;
    logic [RemBits-1:0] sq_shift;
    logic [AluBits-1:0] alu_a;
    logic [AluBits-1:0] alu_b;
    logic [AluBits-1:0] alu_diff;
    logic               alu_ge;
    assign root_mode = (state_reg == ST_RMS_ROOT) || (state_reg == ST_SD_ROOT);
    assign div_shift = {rem_reg[CountBits-1:0], num_reg[WordBits-1]};
    assign sq_shift  = {rem_reg[OutBits-1:0], num_reg[WordBits-1 -: 2]};
    assign alu_a     = root_mode ? {1'b0, sq_shift} : AluBits'(div_shift);
    assign alu_b     = root_mode ? {1'b0, quo_reg[OutBits-1:0], 2'b01}
                                 : AluBits'(count_reg);
    assign alu_diff  = alu_a - alu_b;
    assign alu_ge    = !alu_diff[AluBits-1];

    // last iteration of the running phase
    logic [StepBits-1:0] step_end;
    logic                step_done;
    always_comb begin
        case (state_reg)
            ST_MEAN_DIV: step_end = StepBits'(MeanSteps - 1);
            ST_MS_DIV:   step_end = StepBits'(SquareSteps - 1);
            default:     step_end = StepBits'(RootSteps - 1);
        endcase
    end
    assign step_done = (step_reg == step_end);

    // sample compare and accumulate terms
    logic signed [31:0] sq_prod;
    logic first_valid;
    assign sq_prod     = 32'(s_sample) * 32'(s_sample);
    assign first_valid = (count_reg == '0);

    // magnitude of the sum, clamped mean, mean squared, |ms - m2|
    logic [SumBits-1:0]   sum_neg;
    logic [TotalBits-1:0] smag;
    logic [OutBits-1:0]   mmag_sat;
    logic [OutBits-1:0]   mean_neg;
    logic [WordBits-1:0]  m2_prod;
    logic [WordBits-1:0]  ms_gap;
    assign sum_neg  = -sum_reg;
    assign smag     = sum_reg[SumBits-1] ? sum_neg[TotalBits-1:0] : sum_reg[TotalBits-1:0];
    assign mean_neg = -mmag_reg;
    assign m2_prod  = 64'(mmag_reg) * 64'(mmag_reg);
    assign ms_gap   = (ms_reg >= m2_reg) ? ms_reg - m2_reg : m2_reg - ms_reg;
    always_comb begin
        if (neg_reg) begin
            mmag_sat = (quo_reg > 64'h8000_0000) ? 32'h8000_0000 : quo_reg[OutBits-1:0];
        end else begin
            mmag_sat = (quo_reg > 64'h7fff_ffff) ? 32'h7fff_ffff : quo_reg[OutBits-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_ACC;
            position_reg    <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            square_reg      <= '0;
            min_reg         <= '0;
            max_reg         <= '0;
            min_idx_reg     <= '1;
            max_idx_reg     <= '1;
            quo_reg         <= '0;
            rem_reg         <= '0;
            num_reg         <= '0;
            step_reg        <= '0;
            ms_reg          <= '0;
            m2_reg          <= '0;
            mmag_reg        <= '0;
            rms_reg         <= '0;
            neg_reg         <= 1'b0;
            m_valid         <= 1'b0;
            m_sample_count  <= '0;
            m_total         <= '0;
            m_min_value     <= '0;
            m_min_position  <= '0;
            m_max_value     <= '0;
            m_max_position  <= '0;
            m_mean_value    <= '0;
            m_rms_value     <= '0;
            m_std_deviation <= '0;
            m_has_data      <= 1'b0;
        end else begin
            case (state_reg)
                ST_ACC: begin
                    if (acc_take) begin
                        // accumulate, holding position once full
                        if (position_reg != pos_t'(MaxElements)) begin
                            if (s_valid_req) begin
                                if (first_valid || s_sample < min_reg) begin
                                    min_reg     <= s_sample;
                                    min_idx_reg <= position_reg;
                                end
                                if (first_valid || s_sample > max_reg) begin
                                    max_reg     <= s_sample;
                                    max_idx_reg <= position_reg;
                                end
                                count_reg  <= count_reg + 1'b1;
                                sum_reg    <= sum_reg + SumBits'(s_sample);
                                square_reg <= square_reg + SquareBits'($unsigned(sq_prod));
                            end
                            position_reg <= position_reg + 1'b1;
                        end
                        if (s_last) state_reg <= ST_MEAN_LOAD;
                    end
                end
                ST_MEAN_LOAD: begin
                    // load |sum| scaled by the fraction bits
                    neg_reg  <= sum_reg[SumBits-1];
                    num_reg  <= word_t'(smag) << (WordBits - TotalBits);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    step_reg <= '0;
                    if (count_reg == '0) begin
                        // empty set: skip arithmetic, mean, rms and deviation zero
                        mmag_reg  <= '0;
                        rms_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MEAN_DIV;
                    end
                end
                ST_MEAN_DIV, ST_MS_DIV, ST_RMS_ROOT, ST_SD_ROOT: begin
                    // one divide or root step on the shared subtractor
                    quo_reg <= {quo_reg[WordBits-2:0], alu_ge};
                    if (root_mode) begin
                        num_reg <= num_reg << 2;
                        rem_reg <= alu_ge ? alu_diff[RemBits-1:0] : sq_shift;
                    end else begin
                        num_reg <= num_reg << 1;
                        rem_reg <= RemBits'(alu_ge ? alu_diff[CountBits-1:0]
                                                   : div_shift[CountBits-1:0]);
                    end
                    if (step_done) begin
                        step_reg <= '0;
                        if (state_reg == ST_MEAN_DIV) begin
                            state_reg <= ST_MS_LOAD;
                        end else if (state_reg == ST_MS_DIV) begin
                            state_reg <= ST_RMS_LOAD;
                        end else if (state_reg == ST_RMS_ROOT) begin
                            state_reg <= ST_SD_LOAD;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_MS_LOAD: begin
                    // keep the clamped mean, load the square sum
                    mmag_reg  <= mmag_sat;
                    num_reg   <= word_t'(square_reg) << (WordBits - SquareBits);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_MS_DIV;
                end
                ST_RMS_LOAD: begin
                    // keep the mean square and mean squared, root the mean square
                    ms_reg    <= quo_reg;
                    m2_reg    <= m2_prod;
                    num_reg   <= quo_reg;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_RMS_ROOT;
                end
                ST_SD_LOAD: begin
                    // keep rms, root the gap between mean square and mean squared
                    rms_reg   <= quo_reg[OutBits-1:0];
                    num_reg   <= ms_gap;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_SD_ROOT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        // hand the set to the output registers and clear state
                        m_sample_count  <= count_reg;
                        m_total         <= sum_reg[TotalBits-1:0];
                        m_has_data      <= (count_reg != '0);
                        m_min_value     <= min_reg;
                        m_max_value     <= max_reg;
                        m_min_position  <= min_idx_reg;
                        m_max_position  <= max_idx_reg;
                        m_mean_value    <= neg_reg ? mean_neg : mmag_reg;
                        m_rms_value     <= rms_reg;
                        m_std_deviation <= quo_reg[OutBits-1:0];
                        state_reg       <= ST_ACC;
                        position_reg    <= '0;
                        count_reg       <= '0;
                        sum_reg         <= '0;
                        square_reg      <= '0;
                        min_reg         <= '0;
                        max_reg         <= '0;
                        min_idx_reg     <= '1;
                        max_idx_reg     <= '1;
                    end
                end
                default: state_reg <= ST_ACC;
            endcase
            // raise valid on a new result, drop it once taken
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule
